@@ design/bps_pkg.sv @@
// Shared types and constants of the beep pattern sequencer.
package bps_pkg;

	// Width of the shared serial divider and its iteration counter.
	localparam int DIV_W = 16;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	localparam logic [DIV_W-1:0] FREQ_SCALE = 16'd10;
	localparam logic [DIV_W-1:0] PERIOD_DIVIDEND = 16'd12500;
	localparam logic [7:0] PERIOD_MAX = 8'd255;

	// Register reset values.
	localparam logic [15:0] RST_TONE_FREQUENCY = 16'd1000;
	localparam logic [15:0] RST_ON_TICKS = 16'd100;
	localparam logic [15:0] RST_OFF_TICKS = 16'd100;
	localparam logic [7:0] RST_BEEPS_PER_GROUP = 8'd1;
	localparam logic [7:0] RST_GROUP_COUNT = 8'd1;
	localparam logic [15:0] RST_GROUP_GAP_TICKS = 16'd0;

	typedef enum logic [2:0] {
		REG_TONE_FREQUENCY = 3'd0,
		REG_ON_TICKS = 3'd1,
		REG_OFF_TICKS = 3'd2,
		REG_BEEPS_PER_GROUP = 3'd3,
		REG_GROUP_COUNT = 3'd4,
		REG_GROUP_GAP_TICKS = 3'd5
	} bps_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV_FREQ,
		ST_DIV_PER,
		ST_RES
	} bps_state_t;

	// Control and status between the sequencer and the serial divider.
	typedef struct packed {
		logic start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} bps_div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [DIV_W-1:0] quotient;
	} bps_div_rsp_t;

endpackage

@@ design/bps_ifs.sv @@
// Valid/ready channel interfaces for tick words and status words.
interface bps_tick_if;
	logic valid;
	logic ready;
	logic start_request;
	logic stop_request;

	modport source(output valid, output start_request, output stop_request, input ready);
	modport sink(input valid, input start_request, input stop_request, output ready);
endinterface

interface bps_status_if;
	logic valid;
	logic ready;
	logic tone_on;
	logic [7:0] tone_period;
	logic [6:0] tone_compare;
	logic period_saturated;
	logic busy_res;
	logic done_res;

	modport source(output valid, output tone_on, output tone_period, output tone_compare,
		output period_saturated, output busy_res, output done_res, input ready);
	modport sink(input valid, input tone_on, input tone_period, input tone_compare,
		input period_saturated, input busy_res, input done_res, output ready);
endinterface

@@ design/bps_serdiv.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
module bps_serdiv (
	input logic clk,
	input logic arst_n,
	input bps_pkg::bps_div_req_t req,
	output bps_pkg::bps_div_rsp_t rsp
);
	import bps_pkg::*;

	logic busy_q;
	logic done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] dvd_q;
	logic [DIV_W-1:0] dsr_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W:0] trial;
	logic take;

	// Bring down the next dividend bit and try one subtraction.
	assign trial = {rem_q, dvd_q[DIV_W-1]};
	assign take = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dsr_q <= req.divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
			rem_q <= take ? DIV_W'(trial - {1'b0, dsr_q}) : trial[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], take};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;

endmodule

@@ design/beep_pattern_sequencer.sv @@
// Top level of the beep pattern sequencer: registers, tick sequencing and tone period.
//
// Use: one word on the tick channel per millisecond tick, carrying optional
// start and stop requests. For every tick word the block returns exactly one
// status word: the tone state, the PWM period and compare values, the period
// saturation flag, whether a pattern is still running and a one-tick done pulse.
// The six pattern registers are written over the APB port at byte address 4*i
// and may be read back; writes belong between patterns, when no tick is pending.
// A tick that does not switch the tone on passes through the result state
// ST_RES to the output register. A tick that switches the tone on runs the
// shared bit-serial divider twice (frequency / 10, then 12500 / quotient),
// the second pass skipped when the first quotient is zero, before ST_RES.
// One tick is worked on at a time; the next is taken once the
// status word has moved into the output register.
// The output register holds a status word while the receiver stalls; a new
// tick may be accepted meanwhile, and its result waits until the register
// frees. Reset clears the pattern state, the tone and the output register,
// and loads the registers with their documented defaults.
module beep_pattern_sequencer #(
	parameter int DELAY_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	bps_tick_if.sink tick,
	bps_status_if.source status
);
	import bps_pkg::*;

	localparam int DW = DELAY_WIDTH;

	// Configuration registers.
	logic [15:0] tone_frequency_q;
	logic [15:0] on_ticks_q;
	logic [15:0] off_ticks_q;
	logic [7:0] beeps_per_group_q;
	logic [7:0] group_count_q;
	logic [15:0] group_gap_ticks_q;

	// Pattern state.
	logic active_q, loaded_q, tone_q, sat_q, done_q;
	logic [7:0] groups_q, beeps_q, period_q;
	logic [DW-1:0] on_q, off_q, gap_q;

	// Next values for one tick.
	logic act_n, ld_n, tone_n, done_n, need_div;
	logic [7:0] groups_n, beeps_n;
	logic [DW-1:0] on_n, off_n, gap_n;

	bps_state_t state_q, state_n;
	bps_div_req_t div_req;
	bps_div_rsp_t div_rsp;
	logic out_load, out_valid_q, accept;
	bps_reg_t wr_idx;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign wr_idx = bps_reg_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_frequency_q <= RST_TONE_FREQUENCY;
			on_ticks_q <= RST_ON_TICKS;
			off_ticks_q <= RST_OFF_TICKS;
			beeps_per_group_q <= RST_BEEPS_PER_GROUP;
			group_count_q <= RST_GROUP_COUNT;
			group_gap_ticks_q <= RST_GROUP_GAP_TICKS;
		end else if (cfg_wr) begin
			case (wr_idx)
				REG_TONE_FREQUENCY: tone_frequency_q <= pwdata[15:0];
				REG_ON_TICKS: on_ticks_q <= pwdata[15:0];
				REG_OFF_TICKS: off_ticks_q <= pwdata[15:0];
				REG_BEEPS_PER_GROUP: beeps_per_group_q <= pwdata[7:0];
				REG_GROUP_COUNT: group_count_q <= pwdata[7:0];
				REG_GROUP_GAP_TICKS: group_gap_ticks_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (wr_idx)
			REG_TONE_FREQUENCY: prdata = {16'd0, tone_frequency_q};
			REG_ON_TICKS: prdata = {16'd0, on_ticks_q};
			REG_OFF_TICKS: prdata = {16'd0, off_ticks_q};
			REG_BEEPS_PER_GROUP: prdata = {24'd0, beeps_per_group_q};
			REG_GROUP_COUNT: prdata = {24'd0, group_count_q};
			REG_GROUP_GAP_TICKS: prdata = {16'd0, group_gap_ticks_q};
			default: prdata = '0;
		endcase
	end

	// One tick of the pattern. Stop is applied before start, so both together
	// restart the pattern. The first active tick loads every counter; the
	// delay registers are cut or widened to the counter width on load.
	always_comb begin
		act_n = active_q;
		ld_n = loaded_q;
		groups_n = groups_q;
		beeps_n = beeps_q;
		on_n = on_q;
		off_n = off_q;
		gap_n = gap_q;
		tone_n = tone_q;
		done_n = 1'b0;
		need_div = 1'b0;
		if (tick.stop_request) begin
			act_n = 1'b0;
		end
		if (tick.start_request) begin
			act_n = 1'b1;
			ld_n = 1'b0;
		end
		if (act_n) begin
			if (!ld_n) begin
				ld_n = 1'b1;
				groups_n = group_count_q;
				beeps_n = beeps_per_group_q;
				on_n = DW'(on_ticks_q);
				off_n = DW'(off_ticks_q);
				gap_n = DW'(group_gap_ticks_q);
			end
			if (groups_n != '0) begin
				if (beeps_n != '0) begin
					if (on_n != '0) begin
						on_n = on_n - DW'(1);
						// A turn-on while the tone already sounds keeps the period.
						if (!tone_q) begin
							tone_n = 1'b1;
							need_div = 1'b1;
						end
					end else if (off_n != '0) begin
						off_n = off_n - DW'(1);
						tone_n = 1'b0;
					end else begin
						beeps_n = beeps_n - 8'd1;
						on_n = DW'(on_ticks_q);
						off_n = DW'(off_ticks_q);
					end
				end else if (gap_n != '0) begin
					gap_n = gap_n - DW'(1);
					tone_n = 1'b0;
				end else begin
					groups_n = groups_n - 8'd1;
					beeps_n = beeps_per_group_q;
					gap_n = DW'(group_gap_ticks_q);
				end
			end else begin
				// Groups exhausted: the tone is left as it is until the next idle tick.
				act_n = 1'b0;
				done_n = 1'b1;
			end
		end else begin
			ld_n = 1'b0;
			tone_n = 1'b0;
		end
	end

	assign tick.ready = (state_q == ST_IDLE);
	assign accept = tick.valid && tick.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Sequencer: for a turn-on tick the divider first divides the frequency by
	// ten, then 12500 by that quotient; a zero quotient skips the second pass.
	always_comb begin
		state_n = state_q;
		div_req.start = 1'b0;
		div_req.dividend = tone_frequency_q;
		div_req.divisor = FREQ_SCALE;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (need_div) begin
						div_req.start = 1'b1;
						state_n = ST_DIV_FREQ;
					end else begin
						state_n = ST_RES;
					end
				end
			end
			ST_DIV_FREQ: begin
				if (div_rsp.done) begin
					if (div_rsp.quotient == '0) begin
						state_n = ST_RES;
					end else begin
						div_req.start = 1'b1;
						div_req.dividend = PERIOD_DIVIDEND;
						div_req.divisor = div_rsp.quotient;
						state_n = ST_DIV_PER;
					end
				end
			end
			ST_DIV_PER: begin
				if (div_rsp.done) begin
					state_n = ST_RES;
				end
			end
			ST_RES: begin
				if (!out_valid_q || status.ready) begin
					out_load = 1'b1;
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	bps_serdiv u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			loaded_q <= 1'b0;
			tone_q <= 1'b0;
			sat_q <= 1'b0;
			done_q <= 1'b0;
			groups_q <= '0;
			beeps_q <= '0;
			on_q <= '0;
			off_q <= '0;
			gap_q <= '0;
			period_q <= '0;
		end else begin
			if (accept) begin
				active_q <= act_n;
				loaded_q <= ld_n;
				tone_q <= tone_n;
				done_q <= done_n;
				groups_q <= groups_n;
				beeps_q <= beeps_n;
				on_q <= on_n;
				off_q <= off_n;
				gap_q <= gap_n;
			end
			if (state_q == ST_DIV_FREQ && div_rsp.done && div_rsp.quotient == '0) begin
				period_q <= PERIOD_MAX;
				sat_q <= 1'b1;
			end
			if (state_q == ST_DIV_PER && div_rsp.done) begin
				if (div_rsp.quotient > DIV_W'(PERIOD_MAX)) begin
					period_q <= PERIOD_MAX;
					sat_q <= 1'b1;
				end else begin
					period_q <= div_rsp.quotient[7:0];
					sat_q <= 1'b0;
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (status.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status.tone_on <= tone_q;
			status.tone_period <= period_q;
			status.tone_compare <= period_q[7:1];
			status.period_saturated <= sat_q;
			status.busy_res <= active_q;
			status.done_res <= done_q;
		end
	end

	assign status.valid = out_valid_q;

	a_div_in_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.busy |-> (state_q == ST_DIV_FREQ || state_q == ST_DIV_PER))
		else $error("divider running outside a divide state");

	a_done_inactive: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !active_q)
		else $error("done flagged while pattern still active");

	a_sat_period: assert property (@(posedge clk) disable iff (!arst_n)
		sat_q |-> period_q == PERIOD_MAX)
		else $error("saturation flag without clipped period");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("tick accepted without producing a status word");

	a_load_from_res: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q && state_q == ST_IDLE)
		else $error("status word load did not return to idle");

endmodule

@@ tb/tb_beep_pattern_sequencer.sv @@
// Self-checking testbench for the beep pattern sequencer: tick words in, status words out.
module tb_beep_pattern_sequencer;
	timeunit 1ns;
	timeprecision 1ps;

	import bps_pkg::*;

	localparam int DLY_W = 16;
	// Timeout for the whole run; a correct run needs only a fraction of it.
	localparam int RUN_LIMIT_NS = 15_000_000;
	// The receiver's long hold-off, in cycles.
	localparam int HOLD_OFF_CYCLES = 300;

	// One tick word as the sender queues it.
	typedef struct packed {
		logic start;
		logic stop;
	} tick_word_t;

	// One status word as the block should return it.
	typedef struct packed {
		logic tone_on;
		logic [7:0] period;
		logic [6:0] compare;
		logic saturated;
		logic busy;
		logic done;
	} status_word_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	bps_tick_if tick_ch();
	bps_status_if status_ch();

	beep_pattern_sequencer #(
		.DELAY_WIDTH(DLY_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.tick(tick_ch),
		.status(status_ch)
	);

	always #10 clk = ~clk;

	// Tick words waiting to be offered, and status words still owed by the block.
	tick_word_t pending_ticks[$];
	status_word_t owed_status[$];

	// Shadow copy of the pattern registers, updated as each write lands.
	logic [15:0] cfg_freq = RST_TONE_FREQUENCY;
	logic [15:0] cfg_on = RST_ON_TICKS;
	logic [15:0] cfg_off = RST_OFF_TICKS;
	logic [7:0] cfg_beeps = RST_BEEPS_PER_GROUP;
	logic [7:0] cfg_groups = RST_GROUP_COUNT;
	logic [15:0] cfg_gap = RST_GROUP_GAP_TICKS;

	// Predicted sequencer state, all cleared by reset.
	logic pat_active = 1'b0;
	logic pat_loaded = 1'b0;
	logic [7:0] groups_to_go = '0;
	logic [7:0] beeps_to_go = '0;
	logic [DLY_W-1:0] on_to_go = '0;
	logic [DLY_W-1:0] off_to_go = '0;
	logic [DLY_W-1:0] gap_to_go = '0;
	logic tone_lit = 1'b0;
	logic [7:0] period_q = '0;
	logic clipped = 1'b0;

	int errors = 0;
	int ticks_sent = 0;
	int words_checked = 0;
	int patterns_done = 0;
	int clipped_words = 0;
	int settings_used = 0;
	int hold_token = 0;

	// Sender pacing: a burst of words, then a pause.
	int burst_left = 0;
	int pause_left = 0;

	// Receiver pacing: a randomly redrawn stall rate, plus the long hold-off.
	int rx_cycle = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int hold_seen = 0;

	// A tone switching on computes its PWM period from the live frequency.
	// A switch-on while the tone already sounds leaves period and flag alone.
	function automatic void tone_turn_on();
		int unsigned div, quo;
		if (tone_lit)
			return;
		tone_lit = 1'b1;
		div = cfg_freq / FREQ_SCALE;
		if (div == 0) begin
			// Frequencies below ten leave nothing to divide by.
			period_q = PERIOD_MAX;
			clipped = 1'b1;
		end else begin
			quo = PERIOD_DIVIDEND / div;
			if (quo > PERIOD_MAX) begin
				period_q = PERIOD_MAX;
				clipped = 1'b1;
			end else begin
				period_q = quo[7:0];
				clipped = 1'b0;
			end
		end
	endfunction

	// Advance the predicted sequencer by one tick and queue the status word it owes.
	function automatic void advance_pattern(tick_word_t w);
		status_word_t s;
		logic finished;
		finished = 1'b0;
		// A stop cancels first, then a start re-arms, so both together restart.
		if (w.stop)
			pat_active = 1'b0;
		if (w.start) begin
			pat_active = 1'b1;
			pat_loaded = 1'b0;
		end
		if (pat_active) begin
			if (!pat_loaded) begin
				pat_loaded = 1'b1;
				groups_to_go = cfg_groups;
				beeps_to_go = cfg_beeps;
				on_to_go = cfg_on[DLY_W-1:0];
				off_to_go = cfg_off[DLY_W-1:0];
				gap_to_go = cfg_gap[DLY_W-1:0];
			end
			if (groups_to_go != 0) begin
				if (beeps_to_go != 0) begin
					if (on_to_go != 0) begin
						on_to_go = on_to_go - 1'b1;
						tone_turn_on();
					end else if (off_to_go != 0) begin
						off_to_go = off_to_go - 1'b1;
						tone_lit = 1'b0;
					end else begin
						// End of a beep: reload the beep timers from the live registers.
						beeps_to_go = beeps_to_go - 1'b1;
						on_to_go = cfg_on[DLY_W-1:0];
						off_to_go = cfg_off[DLY_W-1:0];
					end
				end else if (gap_to_go != 0) begin
					gap_to_go = gap_to_go - 1'b1;
					tone_lit = 1'b0;
				end else begin
					groups_to_go = groups_to_go - 1'b1;
					beeps_to_go = cfg_beeps;
					gap_to_go = cfg_gap[DLY_W-1:0];
				end
			end else begin
				// The done tick leaves the tone as it is.
				pat_active = 1'b0;
				finished = 1'b1;
			end
		end else begin
			pat_loaded = 1'b0;
			tone_lit = 1'b0;
		end
		s.tone_on = tone_lit;
		s.period = period_q;
		s.compare = period_q[7:1];
		s.saturated = clipped;
		s.busy = pat_active;
		s.done = finished;
		owed_status.push_back(s);
	endfunction

	function automatic void compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	// Sender. A word offered and not yet taken stays on the bus unchanged.
	always @(posedge clk) begin
		if (arst_n) begin
			if (tick_ch.valid && tick_ch.ready) begin
				advance_pattern(pending_ticks.pop_front());
				ticks_sent++;
				if (burst_left > 0)
					burst_left--;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 40);
					pause_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
			if (tick_ch.valid && !tick_ch.ready) begin
				// Hold the current word until the block takes it.
			end else if (pause_left > 0) begin
				pause_left--;
				tick_ch.valid <= 1'b0;
			end else if (pending_ticks.size() > 0) begin
				tick_ch.valid <= 1'b1;
				tick_ch.start_request <= pending_ticks[0].start;
				tick_ch.stop_request <= pending_ticks[0].stop;
			end else begin
				tick_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver. It stalls at a rate of its own and, on request, holds off for a long
	// stretch so that the output register fills and the block stops taking ticks.
	always @(posedge clk) begin
		if (arst_n) begin
			rx_cycle++;
			if (rx_cycle % 64 == 0) begin
				case ($urandom_range(0, 4))
					0, 1: stall_pct = 0;
					2: stall_pct = 25;
					3: stall_pct = 50;
					default: stall_pct = 85;
				endcase
			end
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				status_ch.ready <= 1'b0;
			end else begin
				status_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// Checker: every status word taken is matched against the oldest one owed.
	always @(posedge clk) begin
		status_word_t want;
		if (arst_n && status_ch.valid && status_ch.ready) begin
			if (owed_status.size() == 0) begin
				$display("%0t ns: status word arrived with none expected", $time);
				errors++;
			end else begin
				want = owed_status.pop_front();
				words_checked++;
				if (want.done)
					patterns_done++;
				if (want.saturated && want.tone_on)
					clipped_words++;
				compare_field("tone_on", want.tone_on, status_ch.tone_on);
				compare_field("tone_period", want.period, status_ch.tone_period);
				compare_field("tone_compare", want.compare, status_ch.tone_compare);
				compare_field("period_saturated", want.saturated, status_ch.period_saturated);
				compare_field("busy_res", want.busy, status_ch.busy_res);
				compare_field("done_res", want.done, status_ch.done_res);
			end
		end
	end

	// Wait until the sender has nothing left and every owed word has come back.
	task automatic drain();
		while (pending_ticks.size() != 0 || owed_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One APB write: a setup phase, then an access phase.
	task automatic reg_write(bps_reg_t r, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (r)
			REG_TONE_FREQUENCY: cfg_freq = value[15:0];
			REG_ON_TICKS: cfg_on = value[15:0];
			REG_OFF_TICKS: cfg_off = value[15:0];
			REG_BEEPS_PER_GROUP: cfg_beeps = value[7:0];
			REG_GROUP_COUNT: cfg_groups = value[7:0];
			REG_GROUP_GAP_TICKS: cfg_gap = value[15:0];
			default: ;
		endcase
	endtask

	// Let the block go idle, then load a whole pattern setting.
	task automatic load_pattern(int freq, int on_t, int off_t, int beeps, int groups, int gap);
		drain();
		reg_write(REG_TONE_FREQUENCY, freq);
		reg_write(REG_ON_TICKS, on_t);
		reg_write(REG_OFF_TICKS, off_t);
		reg_write(REG_BEEPS_PER_GROUP, beeps);
		reg_write(REG_GROUP_COUNT, groups);
		reg_write(REG_GROUP_GAP_TICKS, gap);
		settings_used++;
	endtask

	task automatic queue_ticks(int count, logic start, logic stop);
		tick_word_t w;
		w.start = start;
		w.stop = stop;
		repeat (count) pending_ticks.push_back(w);
	endtask

	// Mostly plain ticks that let a pattern run, with the odd start, stop or restart.
	function automatic tick_word_t random_tick();
		tick_word_t w;
		int r;
		r = $urandom_range(0, 99);
		w.start = (r < 3) || (r == 5);
		w.stop = (r >= 3 && r < 6);
		return w;
	endfunction

	function automatic int pick_freq();
		case ($urandom_range(0, 6))
			0: return $urandom_range(0, 9);
			1: return $urandom_range(10, 499);
			2: return $urandom_range(500, 1300);
			3: return $urandom_range(0, 65535);
			4: return $urandom_range(499, 500);
			5: return 65535;
			default: return $urandom_range(10, 20);
		endcase
	endfunction

	// Mostly short timings so patterns finish often; now and then a large one.
	function automatic int pick_small(int hi, int big);
		return ($urandom_range(0, 7) == 0) ? $urandom_range(0, big) : $urandom_range(0, hi);
	endfunction

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		tick_ch.valid = 1'b0;
		tick_ch.start_request = 1'b0;
		tick_ch.stop_request = 1'b0;
		status_ch.ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset settings: an idle tick, a stop with nothing
		// running, a start that switches the tone on at 1 kHz, a restart with
		// both requests together, then a cancel.
		queue_ticks(1, 1'b0, 1'b0);
		queue_ticks(1, 1'b0, 1'b1);
		queue_ticks(1, 1'b1, 1'b0);
		queue_ticks(2, 1'b0, 1'b0);
		queue_ticks(1, 1'b1, 1'b1);
		queue_ticks(1, 1'b0, 1'b1);
		queue_ticks(1, 1'b0, 1'b0);

		// Two beeps with no silence between them keep the tone on across the
		// beep reload; 10 Hz saturates the period. The group gap switches the tone
		// off before the pattern runs out to done, and idle ticks follow done.
		load_pattern(10, 1, 0, 2, 1, 1);
		queue_ticks(1, 1'b1, 1'b0);
		queue_ticks(8, 1'b0, 1'b0);

		// No groups at all: done on the very first tick; frequency below ten.
		load_pattern(9, 3, 3, 2, 0, 2);
		queue_ticks(1, 1'b1, 1'b0);
		queue_ticks(1, 1'b0, 1'b0);

		// Groups with no beeps only count down and never sound the tone.
		load_pattern(65535, 1, 1, 0, 2, 1);
		queue_ticks(1, 1'b1, 1'b0);
		queue_ticks(6, 1'b0, 1'b0);

		// Random part: nine settings, the largest and the smallest among them.
		for (int ph = 0; ph < 9; ph++) begin
			if (ph == 0)
				load_pattern(65535, 65535, 65535, 255, 255, 65535);
			else if (ph == 1)
				load_pattern(0, 0, 0, 0, 0, 0);
			else
				load_pattern(pick_freq(), pick_small(4, 65535), pick_small(4, 65535),
					pick_small(3, 255), pick_small(3, 255), pick_small(3, 65535));
			// Halfway through, the receiver holds off while the sender keeps offering.
			if (ph == 4)
				hold_token++;
			for (int k = 0; k < 80; k++)
				pending_ticks.push_back(random_tick());
		end

		drain();
		repeat (40) @(posedge clk);
		$display("Sent %0d tick words under %0d register settings and checked %0d status words.",
			ticks_sent, settings_used, words_checked);
		$display("%0d patterns ran to done; %0d words showed a sounding tone with a clipped period.",
			patterns_done, clipped_words);
		if (errors == 0 && owed_status.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("Timeout with %0d status words still owed", owed_status.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule
